### rtl/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared types and constants for the three-channel 3x3 median filter.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int PIX_W          = 8;
  localparam int RGB_W          = 3 * PIX_W;
  localparam int WIN_N          = 9;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int FW_REG_W       = 12;
  localparam int FH_REG_W       = 13;
  localparam int CENTER_ROW_W   = 12;
  localparam int CENTER_COL_W   = 11;

  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [FW_REG_W-1:0] FW_RESET = FW_REG_W'(640);
  localparam logic [FH_REG_W-1:0] FH_RESET = FH_REG_W'(480);

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [RGB_W-1:0] rgb_t;

endpackage

### rtl/rmf_ram.sv
// ----------------------------------------------------------------------------
// rmf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/rmf_median9.sv
// ----------------------------------------------------------------------------
// rmf_median9
// Median of nine 8-bit values by a 19-exchange selection network.
// ----------------------------------------------------------------------------
module rmf_median9 import rmf_pkg::*; (
  input  pix_t v_in [WIN_N],
  output pix_t med
);

  function automatic logic [2*PIX_W-1:0] cx(input pix_t a, input pix_t b);
    // returns {max, min}
    if (a > b) begin
      return {a, b};
    end
    return {b, a};
  endfunction

  always_comb begin
    pix_t v [WIN_N];
    v = v_in;
    {v[2], v[1]} = cx(v[1], v[2]);
    {v[5], v[4]} = cx(v[4], v[5]);
    {v[8], v[7]} = cx(v[7], v[8]);
    {v[1], v[0]} = cx(v[0], v[1]);
    {v[4], v[3]} = cx(v[3], v[4]);
    {v[7], v[6]} = cx(v[6], v[7]);
    {v[2], v[1]} = cx(v[1], v[2]);
    {v[5], v[4]} = cx(v[4], v[5]);
    {v[8], v[7]} = cx(v[7], v[8]);
    {v[3], v[0]} = cx(v[0], v[3]);
    {v[8], v[5]} = cx(v[5], v[8]);
    {v[7], v[4]} = cx(v[4], v[7]);
    {v[6], v[3]} = cx(v[3], v[6]);
    {v[4], v[1]} = cx(v[1], v[4]);
    {v[5], v[2]} = cx(v[2], v[5]);
    {v[7], v[4]} = cx(v[4], v[7]);
    {v[2], v[4]} = cx(v[4], v[2]);
    {v[4], v[6]} = cx(v[6], v[4]);
    {v[2], v[4]} = cx(v[4], v[2]);
    med = v[4];
  end

endmodule

### rtl/rgb_median_filter_3x3.sv
// ----------------------------------------------------------------------------
// rgb_median_filter_3x3
// Streaming 3x3 median filter over raster-order three-channel pixels.
//
//   channel  signals                                   direction  payload
//   pixel    in_valid, in_stall, chan_a/b/c            in         3 x 8 bit
//   result   out_valid, out_stall, med_a/b/c,          out        3 x 8 bit,
//            center_row, center_col, frame_last                   position
//   config   psel, penable, pwrite, paddr, pwdata,     in/out     32 bit APB
//            prdata, pready
//
// One item per cycle sustained while out_stall is low. Between pixel accept
// and result lie the window capture register, then the median network into
// the output register. Both line stores share one RAM whose registered read is
// prefetched at the next column. in_stall rises only while both stages hold
// an item and out_stall is high. Reset clears counters, valid flags and config
// registers; line stores stay undefined. Border pixels give no result.
// ----------------------------------------------------------------------------
module rgb_median_filter_3x3 import rmf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  pix_t                    chan_a,
  input  pix_t                    chan_b,
  input  pix_t                    chan_c,
  output logic                    out_valid,
  input  logic                    out_stall,
  output pix_t                    med_a,
  output pix_t                    med_b,
  output pix_t                    med_c,
  output logic [CENTER_ROW_W-1:0] center_row,
  output logic [CENTER_COL_W-1:0] center_col,
  output logic                    frame_last,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP  = (WW > FW_REG_W) ? WW : FW_REG_W;
  localparam int HCMP  = (HW > FH_REG_W) ? HW : FH_REG_W;

  // configuration
  logic [FW_REG_W-1:0] frame_width;
  logic [FH_REG_W-1:0] frame_height;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // effective dimensions
  logic [WCMP-1:0] fw_ext;
  logic [HCMP-1:0] fh_ext;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;

  always_comb begin
    fw_ext = WCMP'(frame_width);
    fh_ext = HCMP'(frame_height);
    if (fw_ext < WCMP'(3)) begin
      w_eff = WW'(3);
    end else if (fw_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext[WW-1:0];
    end
    if (fh_ext < HCMP'(3)) begin
      h_eff = HW'(3);
    end else if (fh_ext > HCMP'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = fh_ext[HW-1:0];
    end
  end

  // handshake
  logic s1_valid;
  logic s2_ready;
  logic s1_ready;
  logic accept;

  assign s2_ready = !out_valid || !out_stall;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;
  assign accept   = in_valid && !in_stall;

  // position counters
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count_next;
  logic [RW-1:0] row_count_next;
  logic [WW-1:0] col_p1;
  logic [HW-1:0] row_p1;
  logic          col_wrap;
  logic          row_wrap;
  logic          interior;

  always_comb begin
    col_p1   = WW'(col_count) + WW'(1);
    row_p1   = HW'(row_count) + HW'(1);
    col_wrap = col_p1 >= w_eff;
    row_wrap = row_p1 >= h_eff;
    interior = (row_count >= RW'(2)) && (col_count >= CW'(2));
    if (col_wrap) begin
      col_count_next = '0;
      row_count_next = row_wrap ? '0 : row_p1[RW-1:0];
    end else begin
      col_count_next = col_p1[CW-1:0];
      row_count_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // line stores: {older, newer} in one RAM
  rgb_t              pix;
  logic [2*RGB_W-1:0] ls_rd;
  rgb_t              top;
  rgb_t              mid;

  assign pix = {chan_c, chan_b, chan_a};
  assign top = ls_rd[2*RGB_W-1:RGB_W];
  assign mid = ls_rd[RGB_W-1:0];

  rmf_ram #(
    .WIDTH (2 * RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_count),
    .wr_data ({mid, pix}),
    .rd_addr (accept ? col_count_next : col_count),
    .rd_data (ls_rd)
  );

  // window columns c-2, c-1 for top, middle, bottom rows
  rgb_t wcol [6];

  always_ff @(posedge clk) begin
    if (accept) begin
      wcol[0] <= wcol[1];
      wcol[1] <= top;
      wcol[2] <= wcol[3];
      wcol[3] <= mid;
      wcol[4] <= wcol[5];
      wcol[5] <= pix;
    end
  end

  // stage 1: captured window
  rgb_t                    s1_win [WIN_N];
  logic [CENTER_ROW_W-1:0] s1_row;
  logic [CENTER_COL_W-1:0] s1_col;
  logic                    s1_last;
  logic                    s1_load;

  assign s1_load = accept && interior;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_win[0] <= wcol[0];
      s1_win[1] <= wcol[1];
      s1_win[2] <= top;
      s1_win[3] <= wcol[2];
      s1_win[4] <= wcol[3];
      s1_win[5] <= mid;
      s1_win[6] <= wcol[4];
      s1_win[7] <= wcol[5];
      s1_win[8] <= pix;
      s1_row    <= CENTER_ROW_W'(row_count - RW'(1));
      s1_col    <= CENTER_COL_W'(col_count - CW'(1));
      s1_last   <= col_wrap && row_wrap;
    end
  end

  // median network per channel
  pix_t ch_a [WIN_N];
  pix_t ch_b [WIN_N];
  pix_t ch_c [WIN_N];
  pix_t med_a_next;
  pix_t med_b_next;
  pix_t med_c_next;

  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      ch_a[i] = s1_win[i][PIX_W-1:0];
      ch_b[i] = s1_win[i][2*PIX_W-1:PIX_W];
      ch_c[i] = s1_win[i][3*PIX_W-1:2*PIX_W];
    end
  end

  rmf_median9 u_med_a (.v_in(ch_a), .med(med_a_next));
  rmf_median9 u_med_b (.v_in(ch_b), .med(med_b_next));
  rmf_median9 u_med_c (.v_in(ch_c), .med(med_c_next));

  // stage 2: output register
  logic s2_load;

  assign s2_load = s1_valid && s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      med_a      <= med_a_next;
      med_b      <= med_b_next;
      med_c      <= med_c_next;
      center_row <= s1_row;
      center_col <= s1_col;
      frame_last <= s1_last;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with a free stage");

  a_interior_captured: assert property (@(posedge clk) disable iff (rst)
    s1_load |=> s1_valid)
    else $error("interior item not captured");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && col_wrap |=> col_count == '0)
    else $error("column counter failed to wrap");

  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    accept && !col_wrap |=> $stable(row_count))
    else $error("row counter moved inside a row");

endmodule
